// ===== hw/rtl/sksp_pkg.sv =====
// shared types and constants for the slater-koster s/p block
package sksp_pkg;

  // number of result rows per bond
  localparam int unsigned NumRows = 4;

  // matrix row codes, also carried on the output tuser
  typedef enum logic [1:0] {
    ROW_S  = 2'd0,
    ROW_PX = 2'd1,
    ROW_PY = 2'd2,
    ROW_PZ = 2'd3
  } row_e;

endpackage

// ===== hw/rtl/sksp_front.sv =====
// front part: input beat intake, p-p difference, two-entry bond queue
module sksp_front
  import sksp_pkg::*;
#(
  parameter int unsigned CosW = 16,
  parameter int unsigned IntW = 32,
  parameter int unsigned InW  = 3 * CosW + 5 * IntW,
  parameter int unsigned ItemW = 3 * CosW + 5 * IntW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [InW-1:0]   in_data_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  // cos_x, cos_y, cos_z, ss_sigma, sp_sigma_fwd, sp_sigma_rev, pp_pi, d
  output logic [ItemW-1:0] q_item_o
);

  logic signed [IntW-1:0] pp_sigma;
  logic signed [IntW-1:0] pp_pi;
  logic signed [IntW:0]   pp_diff;
  logic [ItemW-1:0]       item_in;
  logic [ItemW-1:0]       mem_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push;
  logic                   pop;

  // split out the p-p integrals and form sigma minus pi
  assign pp_sigma = in_data_i[3*CosW+4*IntW-1 -: IntW];
  assign pp_pi    = in_data_i[3*CosW+5*IntW-1 -: IntW];
  assign pp_diff  = {pp_sigma[IntW-1], pp_sigma} - {pp_pi[IntW-1], pp_pi};
  assign item_in  = {pp_diff, pp_pi, in_data_i[3*CosW+3*IntW-1:0]};

  // queue control
  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== hw/rtl/sksp_back.sv =====
// back part: row sequencer, two multiply stages, rounding and saturation
module sksp_back
  import sksp_pkg::*;
#(
  parameter int unsigned CosW = 16,
  parameter int unsigned IntW = 32,
  parameter int unsigned ItemW = 3 * CosW + 5 * IntW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  logic [ItemW-1:0] q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output row_e             out_row_o,
  output logic [IntW-1:0]  out_col_o [4]
);

  localparam int unsigned CFrac = CosW - 1;
  localparam int unsigned CcW   = 2 * CosW;
  localparam int unsigned BW    = IntW + 1;
  localparam int unsigned PW    = CcW + BW;
  localparam int unsigned SrW   = CosW + IntW + 1;
  localparam int unsigned EW    = IntW + 5;
  localparam logic signed [PW:0] HalfP =
    {{(PW + 1 - 2 * CFrac){1'b0}}, 1'b1, {(2 * CFrac - 1){1'b0}}};
  localparam logic signed [SrW:0] HalfS =
    {{(SrW + 1 - CFrac){1'b0}}, 1'b1, {(CFrac - 1){1'b0}}};

  // clamp a widened element to the signed integral range
  function automatic logic [IntW-1:0] sat(input logic [EW-1:0] v);
    logic [5:0] top;
    top = v[EW-1:IntW-1];
    if ((&top) || !(|top)) begin
      return v[IntW-1:0];
    end else if (v[EW-1]) begin
      return {1'b1, {(IntW - 1){1'b0}}};
    end else begin
      return {1'b0, {(IntW - 1){1'b1}}};
    end
  endfunction

  logic signed [CosW-1:0] cos_v [3];
  logic signed [IntW-1:0] ss, fwd, rev, ppi;
  logic signed [IntW:0]   pp_diff;
  logic signed [CosW-1:0] ci;
  logic signed [CcW-1:0]  a_d [3];
  logic signed [BW-1:0]   b_d;
  logic signed [SrW-1:0]  sr_d;
  logic                   adv;
  logic                   issue;
  row_e                   row_q, row_d;

  // stage 1 registers
  logic                   s1_vld_q;
  row_e                   s1_row_q;
  logic signed [CcW-1:0]  s1_a_q [3];
  logic signed [BW-1:0]   s1_b_q;
  logic signed [SrW-1:0]  s1_sr_q;
  logic signed [IntW-1:0] s1_ss_q, s1_ppi_q;

  // stage 2 registers
  logic                   s2_vld_q;
  row_e                   s2_row_q;
  logic signed [PW-1:0]   s2_p_q [3];
  logic signed [SrW-1:0]  s2_sr_q;
  logic signed [IntW-1:0] s2_ss_q, s2_ppi_q;

  // output registers
  logic                   out_vld_q;
  row_e                   out_row_q;
  logic [IntW-1:0]        out_col_q [4];
  logic [IntW-1:0]        col_d [4];

  // unpack the queued bond
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cos_v[k] = q_item_i[k*CosW +: CosW];
    end
    ss      = q_item_i[3*CosW +: IntW];
    fwd     = q_item_i[3*CosW+IntW +: IntW];
    rev     = q_item_i[3*CosW+2*IntW +: IntW];
    ppi     = q_item_i[3*CosW+3*IntW +: IntW];
    pp_diff = q_item_i[3*CosW+4*IntW +: IntW+1];
  end

  // whole pipeline moves when the output register can take a beat
  assign adv     = !out_vld_q || out_ready_i;
  assign issue   = adv && q_valid_i;
  assign q_pop_o = issue && (row_q == ROW_PZ);

  // row sequencer
  always_comb begin
    unique case (row_q)
      ROW_S:   row_d = ROW_PX;
      ROW_PX:  row_d = ROW_PY;
      ROW_PY:  row_d = ROW_PZ;
      ROW_PZ:  row_d = ROW_S;
      default: row_d = ROW_S;
    endcase
  end

  // stage 1 operands: row 0 scales cosines up, p rows form cosine products
  always_comb begin
    unique case (row_q)
      ROW_PX:  ci = cos_v[0];
      ROW_PY:  ci = cos_v[1];
      ROW_PZ:  ci = cos_v[2];
      default: ci = '0;
    endcase
    for (int k = 0; k < 3; k++) begin
      if (row_q == ROW_S) begin
        a_d[k] = {cos_v[k][CosW-1], cos_v[k], {CFrac{1'b0}}};
      end else begin
        a_d[k] = ci * cos_v[k];
      end
    end
    if (row_q == ROW_S) begin
      b_d = {fwd[IntW-1], fwd};
    end else begin
      b_d = pp_diff;
    end
    sr_d = -(ci * rev);
  end

  // stage 3 logic: round, add pi on the diagonal, saturate; column 0 of the s row takes ss_sigma as is
  always_comb begin
    logic signed [PW:0]     rp;
    logic signed [IntW+3:0] t;
    logic signed [SrW:0]    rs;
    logic signed [IntW+2:0] ts;
    logic [EW-1:0]          e;
    for (int k = 0; k < 3; k++) begin
      rp = {s2_p_q[k][PW-1], s2_p_q[k]} + HalfP;
      t  = rp[PW:2*CFrac];
      if (s2_row_q != ROW_S && (int'(s2_row_q) == k + 1)) begin
        e = {t[IntW+3], t} + {{5{s2_ppi_q[IntW-1]}}, s2_ppi_q};
      end else begin
        e = {t[IntW+3], t};
      end
      col_d[k+1] = sat(e);
    end
    rs = {s2_sr_q[SrW-1], s2_sr_q} + HalfS;
    ts = rs[SrW:CFrac];
    if (s2_row_q == ROW_S) begin
      col_d[0] = s2_ss_q;
    end else begin
      col_d[0] = sat({{2{ts[IntW+2]}}, ts});
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= ROW_S;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        row_q <= row_d;
      end
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q <= row_q;
      s1_a_q   <= a_d;
      s1_b_q   <= b_d;
      s1_sr_q  <= sr_d;
      s1_ss_q  <= ss;
      s1_ppi_q <= ppi;
      s2_row_q <= s1_row_q;
      for (int k = 0; k < 3; k++) begin
        s2_p_q[k] <= s1_a_q[k] * s1_b_q;
      end
      s2_sr_q   <= s1_sr_q;
      s2_ss_q   <= s1_ss_q;
      s2_ppi_q  <= s1_ppi_q;
      out_row_q <= s2_row_q;
      out_col_q <= col_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

endmodule

// ===== hw/rtl/slater_koster_sp_block.sv =====
// path: bond queue, then stage 1, stage 2 and output registers, rows in order
// throughput: one result row per cycle from the row sequencer unless the output stalls
// a two-entry bond queue lets input beats land while the output side stalls
// reset: asynchronous active low, clears queue pointers, row counter and stage valids
// no clearing pass, the block holds no state between bonds
module slater_koster_sp_block
  import sksp_pkg::*;
#(
  parameter int unsigned COSINE_WIDTH   = 16,
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cos_x, cos_y, cos_z, ss_sigma, sp_sigma_fwd, sp_sigma_rev, pp_sigma, pp_pi
  input  logic [((3*COSINE_WIDTH+5*INTEGRAL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // col_s, col_px, col_py, col_pz
  output logic [((4*INTEGRAL_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // row_index
  output logic [1:0] m_axis_tuser,
  // last_row
  output logic m_axis_tlast
);

  localparam int unsigned InW   = 3 * COSINE_WIDTH + 5 * INTEGRAL_WIDTH;
  localparam int unsigned ItemW = InW + 1;
  localparam int unsigned OutW  = 4 * INTEGRAL_WIDTH;
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8;

  logic                      q_valid;
  logic                      q_pop;
  logic [ItemW-1:0]          q_item;
  row_e                      out_row;
  logic [INTEGRAL_WIDTH-1:0] out_col [4];

  // intake and bond queue
  sksp_front #(
    .CosW  (COSINE_WIDTH),
    .IntW  (INTEGRAL_WIDTH),
    .InW   (InW),
    .ItemW (ItemW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[InW-1:0]),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  // row generation
  sksp_back #(
    .CosW  (COSINE_WIDTH),
    .IntW  (INTEGRAL_WIDTH),
    .ItemW (ItemW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col)
  );

  // output beat packing
  assign m_axis_tdata = OutTW'({out_col[3], out_col[2], out_col[1], out_col[0]});
  assign m_axis_tuser = out_row;
  assign m_axis_tlast = (out_row == ROW_PZ);

endmodule

// ===== verif/slater_koster_sp_block_tb.sv =====
// self-checking stream testbench for the slater-koster s/p block
module slater_koster_sp_block_tb;
  import sksp_pkg::*;

  localparam int unsigned CosW      = 16;
  localparam int unsigned IntW      = 32;
  localparam int unsigned InW       = ((3*CosW+5*IntW+7)/8)*8;
  localparam int unsigned OutW      = ((4*IntW+7)/8)*8;
  localparam int unsigned CosFrac   = CosW - 1;
  localparam int unsigned NumRandom = 300;
  localparam int unsigned IdleLimit = 5000;
  localparam longint      SatHi     = 64'sd2147483647;
  localparam longint      SatLo     = -64'sd2147483648;

  // one bond as packed on the input tdata, cos_x in the lowest bits
  typedef struct packed {
    logic signed [IntW-1:0] pp_pi;
    logic signed [IntW-1:0] pp_sigma;
    logic signed [IntW-1:0] sp_rev;
    logic signed [IntW-1:0] sp_fwd;
    logic signed [IntW-1:0] ss_sigma;
    logic signed [CosW-1:0] cos_z;
    logic signed [CosW-1:0] cos_y;
    logic signed [CosW-1:0] cos_x;
  } bond_t;

  // one matrix row as seen on tlast, tuser and tdata
  typedef struct packed {
    logic                       last;
    row_e                       row;
    logic [3:0][IntW-1:0]       col;
  } sk_row_t;

  // predicts the four rows of each accepted bond and checks them in order
  class sk_row_board;
    sk_row_t pending_rows[$];
    int      errors = 0;

    function logic [IntW-1:0] sat_int(longint v);
      if (v > SatHi) return SatHi[IntW-1:0];
      if (v < SatLo) return SatLo[IntW-1:0];
      return v[IntW-1:0];
    endfunction

    // round to nearest with ties up, arithmetic shift gives the floor
    function longint round_drop(longint v, int unsigned bits);
      return (v + (longint'(1) << (bits - 1))) >>> bits;
    endfunction

    function void note_bond(bond_t b);
      longint  c[3];
      longint  d;
      longint  t;
      sk_row_t r;
      c[0] = longint'(b.cos_x);
      c[1] = longint'(b.cos_y);
      c[2] = longint'(b.cos_z);
      d    = longint'(b.pp_sigma) - longint'(b.pp_pi);
      // s row
      r.last   = 1'b0;
      r.row    = ROW_S;
      r.col[0] = sat_int(longint'(b.ss_sigma));
      for (int j = 0; j < 3; j++)
        r.col[j+1] = sat_int(round_drop(c[j] * longint'(b.sp_fwd), CosFrac));
      pending_rows.push_back(r);
      // p rows
      for (int i = 0; i < 3; i++) begin
        r.last   = (i == 2);
        r.row    = row_e'(i + 1);
        r.col[0] = sat_int(round_drop(-(c[i] * longint'(b.sp_rev)), CosFrac));
        for (int j = 0; j < 3; j++) begin
          t = round_drop(c[i] * c[j] * d, 2 * CosFrac);
          if (i == j) t = t + longint'(b.pp_pi);
          r.col[j+1] = sat_int(t);
        end
        pending_rows.push_back(r);
      end
    endfunction

    function void check_row(sk_row_t got);
      sk_row_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row, actual row %0d last %0b data %h",
                 $time, got.row, got.last, got.col);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (got.row !== want.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: row %0d last_row expected %0b actual %0b",
                 $time, want.row, want.last, got.last);
        errors++;
      end
      for (int j = 0; j < 4; j++) begin
        if (got.col[j] !== want.col[j]) begin
          $display("%0t: row %0d column %0d expected %h actual %h",
                   $time, want.row, j, want.col[j], got.col[j]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  // cos_x, cos_y, cos_z, ss_sigma, sp_sigma_fwd, sp_sigma_rev, pp_sigma, pp_pi
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  // col_s, col_px, col_py, col_pz
  logic [OutW-1:0] m_axis_tdata;
  // row_index
  logic [1:0]      m_axis_tuser;
  // last_row
  logic            m_axis_tlast;

  sk_row_board board = new();
  int unsigned idle_cycles = 0;

  slater_koster_sp_block #(
    .COSINE_WIDTH  (CosW),
    .INTEGRAL_WIDTH(IntW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // beat monitor and idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      board.note_bond(bond_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_row({m_axis_tlast, row_e'(m_axis_tuser), m_axis_tdata[4*IntW-1:0]});
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[slater_koster_sp_block] ERROR");
      $finish;
    end
  end

  // receiver: stretches of always ready, random stalls and periodic stalls
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned period;
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(20, 200);
      stall   = $urandom_range(1, 12);
      period  = stall + $urandom_range(1, 8);
      for (int unsigned k = 0; k < stretch; k++) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((k % period) >= stall);
        endcase
      end
    end
  end

  function automatic bond_t make_bond(int cx, int cy, int cz, int ss, int fwd, int rev,
                                      int psig, int ppi);
    bond_t b;
    b.cos_x    = cx[CosW-1:0];
    b.cos_y    = cy[CosW-1:0];
    b.cos_z    = cz[CosW-1:0];
    b.ss_sigma = ss;
    b.sp_fwd   = fwd;
    b.sp_rev   = rev;
    b.pp_sigma = psig;
    b.pp_pi    = ppi;
    return b;
  endfunction

  // cosine codes biased toward the extremes and small values
  function automatic logic [CosW-1:0] rand_cosine();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CosW-1){1'b0}}};
      1: return {1'b0, {(CosW-1){1'b1}}};
      2: return '0;
      3: return CosW'($urandom_range(0, 6) - 3);
      default: return CosW'($urandom);
    endcase
  endfunction

  // integrals biased toward the limits and small values
  function automatic logic [IntW-1:0] rand_integral();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(IntW-1){1'b0}}};
      1: return {1'b0, {(IntW-1){1'b1}}};
      2: return IntW'($urandom_range(0, 64) - 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic bond_t rand_bond();
    bond_t b;
    b.cos_x    = rand_cosine();
    b.cos_y    = rand_cosine();
    b.cos_z    = rand_cosine();
    b.ss_sigma = rand_integral();
    b.sp_fwd   = rand_integral();
    b.sp_rev   = rand_integral();
    b.pp_sigma = rand_integral();
    b.pp_pi    = rand_integral();
    return b;
  endfunction

  // present one bond and hold it until its beat is taken
  task automatic send_bond(input bond_t b);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    bond_t       directed[$];
    int unsigned sent;
    int unsigned burst;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all zero, and unit cosines with plain integrals
    directed.push_back(make_bond(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_bond(32767, 0, 0, 'h0100_0000, 'h0080_0000, 'h0040_0000,
                                 'h0200_0000, 'h0010_0000));
    directed.push_back(make_bond(0, -32768, 0, -'h0100_0000, 'h0123_4567, -'h0076_5432,
                                 -'h0200_0000, 'h0300_0000));
    directed.push_back(make_bond(0, 0, 32767, 'h7fff_ffff, 'h7fff_ffff, 'h7fff_ffff,
                                 'h7fff_ffff, 'h7fff_ffff));
    // minus one times the most negative integral saturates high
    directed.push_back(make_bond(-32768, -32768, -32768, 'h8000_0000, 'h8000_0000,
                                 'h8000_0000, 'h7fff_ffff, 'h8000_0000));
    directed.push_back(make_bond(-32768, 32767, -32768, 'h8000_0000, 'h7fff_ffff,
                                 'h8000_0000, 'h8000_0000, 'h7fff_ffff));
    directed.push_back(make_bond(32767, 32767, 32767, 'h7fff_ffff, 'h8000_0000,
                                 'h7fff_ffff, 'h7fff_ffff, 'h8000_0000));
    // diagonal sums of pi and a large term that land exactly on the signed limits
    directed.push_back(make_bond(-32768, 0, 0, 0, 0, 0, 'h7fff_ffff, 'h4000_0000));
    directed.push_back(make_bond(-32768, 0, 0, 0, 0, 0, 'h8000_0000, -'h4000_0000));
    // rounding ties go toward plus infinity
    directed.push_back(make_bond(1, -1, 1, 1, 'h4000, 'h4000, 'h2000_0000, 0));
    directed.push_back(make_bond(1, -1, -1, -1, -'h4000, -'h4000, -'h2000_0000, 0));
    directed.push_back(make_bond(3, 3, -3, 7, 'h4000, -'h4000, 'h2000_0000, 1));
    // cosines off and on the unit sphere, all ones and alternating bit patterns
    directed.push_back(make_bond(23170, 23170, 23170, 'h0120_0000, 'h0234_5678,
                                 'h0345_6789, 'h0500_0000, -'h0100_0000));
    directed.push_back(make_bond(18919, -18919, 18918, -'h0120_0000, -'h0234_5678,
                                 'h0345_6789, -'h0500_0000, 'h0100_0000));
    directed.push_back(make_bond(-1, -1, -1, -1, -1, -1, -1, -1));
    directed.push_back(make_bond('h5555, 'haaaa, 'h5555, 'h5555_5555, 'haaaa_aaaa,
                                 'h5555_5555, 'haaaa_aaaa, 'h5555_5555));
    foreach (directed[i]) send_bond(directed[i]);
    hold_off(0);
    wait_drained();

    // random bursts with gaps, now and then a full drain
    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 12);
      for (int unsigned k = 0; k < burst && sent < NumRandom; k++) begin
        send_bond(rand_bond());
        sent++;
      end
      case ($urandom_range(0, 9))
        0: begin
          hold_off(0);
          wait_drained();
        end
        1, 2: ;
        default: hold_off($urandom_range(0, 15));
      endcase
    end

    // drain and let the pipeline settle
    hold_off(0);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("[slater_koster_sp_block] OK");
    else
      $display("[slater_koster_sp_block] ERROR");
    $finish;
  end

endmodule
